[design/ssr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types, widths and codes of the supersample resolve block.
// ----------------------------------------------------------------------------
package ssr_pkg;

   localparam int DEF_MAX_OUT_WIDTH = 2048;
   localparam int DEF_MAX_FACTOR    = 8;

   localparam int DEPTH_W    = 32;
   localparam int COLOR_W    = 16;
   localparam int FACTOR_W   = 4;
   localparam int WIDTH_W    = 12;
   localparam int ALPHA_W    = 17;
   localparam int SUM_W      = 22;
   localparam int CNT_W      = 7;
   localparam int SC_W       = WIDTH_W + FACTOR_W;
   localparam int DEN_W      = 2 * FACTOR_W + 1;
   localparam int NUM_W      = 23;
   localparam int DIV_CNT_W  = 5;
   localparam int OUTCOL_W   = 11;
   localparam int MEM_W      = 3 * SUM_W + CNT_W;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'h10000;
   localparam logic [DEPTH_W-1:0] FAR_LOW    = 32'h7F00_0000;
   localparam logic [DEPTH_W-1:0] FAR_HIGH   = 32'h7F80_0000;
   localparam logic [COLOR_W-1:0] COLOR_ONE  = 16'h8000;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_FACTOR       = 4'd0;
   localparam csr_idx_type CSR_OUT_WIDTH    = 4'd1;
   localparam csr_idx_type CSR_GLOBAL_ALPHA = 4'd2;
   localparam csr_idx_type CSR_TARGET_MODE  = 4'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POS_START,
      ST_POS_WAIT,
      ST_READ,
      ST_RMW,
      ST_RES_PREP,
      ST_RES_START,
      ST_RES_WAIT,
      ST_MUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic pos_start;
      logic pos_load;
      logic mem_read;
      logic rmw;
      logic res_prep;
      logic res_start;
      logic mul;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic pos_dirty;
      logic div_idle;
      logic last_sample;
      logic rsp_free;
   } status_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth_bits;
      logic [COLOR_W-1:0] sample_red;
      logic [COLOR_W-1:0] sample_green;
      logic [COLOR_W-1:0] sample_blue;
      logic [COLOR_W-1:0] target_red;
      logic [COLOR_W-1:0] target_green;
      logic [COLOR_W-1:0] target_blue;
   } req_data_type;

   typedef struct packed {
      logic [COLOR_W-1:0]  out_red;
      logic [COLOR_W-1:0]  out_green;
      logic [COLOR_W-1:0]  out_blue;
      logic [OUTCOL_W-1:0] out_column;
      logic                row_end;
   } rsp_data_type;

endpackage

[design/ssr_ifaces.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_ifaces
// Valid/ready channels of the resolve block: samples in, pixels out, CSR write.
// ----------------------------------------------------------------------------
interface ssr_req_if import ssr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DEPTH_W-1:0] depth_bits;
   logic [COLOR_W-1:0] sample_red;
   logic [COLOR_W-1:0] sample_green;
   logic [COLOR_W-1:0] sample_blue;
   logic [COLOR_W-1:0] target_red;
   logic [COLOR_W-1:0] target_green;
   logic [COLOR_W-1:0] target_blue;
   modport source (output valid, depth_bits, sample_red, sample_green, sample_blue,
                   target_red, target_green, target_blue, input ready);
   modport sink (input valid, depth_bits, sample_red, sample_green, sample_blue,
                 target_red, target_green, target_blue, output ready);
endinterface

interface ssr_rsp_if import ssr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COLOR_W-1:0]  out_red;
   logic [COLOR_W-1:0]  out_green;
   logic [COLOR_W-1:0]  out_blue;
   logic [OUTCOL_W-1:0] out_column;
   logic                row_end;
   modport source (output valid, out_red, out_green, out_blue, out_column, row_end,
                   input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_column, row_end,
                 output ready);
endinterface

interface ssr_csr_if import ssr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[design/supersample_resolve_alpha_composite.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supersample_resolve_alpha_composite
// Box-filter resolve of supersampled pixels with coverage alpha-over blend.
// ----------------------------------------------------------------------------
//  channel   dir   transfer              payload
//  req_in    in    valid & ready         depth, sample rgb, target rgb
//  rsp_out   out   valid & ready         blended rgb, column, row end
//  csr_in    in    valid & ready         index, data (always ready)
//
//  A sample passes through accept, memory read and read-modify-write.
//  A block-completing sample then runs the 23-step serial dividers that
//  average color and coverage, then the blend multiply, and loads the
//  output register once it is free. The first sample after a CSR write
//  first splits the sample position with the same dividers.
//  After reset every accumulator memory entry is cleared with req_in
//  not ready. A stalled result holds in the output register while the
//  next samples are taken.
// ----------------------------------------------------------------------------
module supersample_resolve_alpha_composite import ssr_pkg::*; #(
   parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
   parameter int MAX_FACTOR    = DEF_MAX_FACTOR
) (
   input  logic     clock,
   input  logic     reset,
   ssr_req_if.sink  req_in,
   ssr_rsp_if.source rsp_out,
   ssr_csr_if.sink  csr_in
);

   cmd_type      cmd;
   status_type   status;
   req_data_type req_data;
   rsp_data_type rsp_data;
   logic         rsp_valid;

   assign req_data.depth_bits   = req_in.depth_bits;
   assign req_data.sample_red   = req_in.sample_red;
   assign req_data.sample_green = req_in.sample_green;
   assign req_data.sample_blue  = req_in.sample_blue;
   assign req_data.target_red   = req_in.target_red;
   assign req_data.target_green = req_in.target_green;
   assign req_data.target_blue  = req_in.target_blue;

   assign csr_in.ready = 1'b1;

   ssr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_in.valid),
      .req_ready (req_in.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssr_dp #(
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
      .MAX_FACTOR    (MAX_FACTOR)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_write (csr_in.valid),
      .csr_index (csr_in.index),
      .csr_data  (csr_in.data),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_out.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_out.valid      = rsp_valid;
   assign rsp_out.out_red    = rsp_data.out_red;
   assign rsp_out.out_green  = rsp_data.out_green;
   assign rsp_out.out_blue   = rsp_data.out_blue;
   assign rsp_out.out_column = rsp_data.out_column;
   assign rsp_out.row_end    = rsp_data.row_end;

endmodule

[design/ssr_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssr_div import ssr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             idle,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0]     quo_ff;
   logic [DEN_W-1:0]     rem_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [DEN_W:0]       shifted;
   logic [DEN_W+1:0]     diff;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DIV_CNT_W'(NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], ~diff[DEN_W+1]};
         rem_ff <= diff[DEN_W+1] ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
      end
   end

   assign idle = ~busy_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

[design/ssr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_ctrl
// Sequencer: memory clear, position recompute, accumulate, resolve, output.
// ----------------------------------------------------------------------------
module ssr_ctrl import ssr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = status.pos_dirty ? ST_POS_START : ST_READ;
         end
         ST_POS_START: state_in = ST_POS_WAIT;
         ST_POS_WAIT: begin
            if (status.div_idle) state_in = ST_READ;
         end
         ST_READ: state_in = ST_RMW;
         ST_RMW: state_in = status.last_sample ? ST_RES_PREP : ST_IDLE;
         ST_RES_PREP: state_in = ST_RES_START;
         ST_RES_START: state_in = ST_RES_WAIT;
         ST_RES_WAIT: begin
            if (status.div_idle) state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_OUT;
         ST_OUT: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_POS_START: cmd.pos_start = 1'b1;
         ST_POS_WAIT: cmd.pos_load = status.div_idle;
         ST_READ: cmd.mem_read = 1'b1;
         ST_RMW: cmd.rmw = 1'b1;
         ST_RES_PREP: cmd.res_prep = 1'b1;
         ST_RES_START: cmd.res_start = 1'b1;
         ST_RES_WAIT: cmd = '0;
         ST_MUL: cmd.mul = 1'b1;
         ST_OUT: cmd.out_load = status.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

[design/ssr_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_dp
// Datapath: CSRs, sample position, column accumulator memory, divider lanes,
// blend multipliers and the output register.
// ----------------------------------------------------------------------------
module ssr_dp import ssr_pkg::*; #(
   parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
   parameter int MAX_FACTOR    = DEF_MAX_FACTOR
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_data_type          rsp_data
);

   localparam int COL_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
   localparam int CLR_W = COL_W + 1;
   localparam int WCMP_W = WIDTH_W + 2;

   // configuration
   logic [FACTOR_W-1:0] factor_ff;
   logic [WIDTH_W-1:0]  out_width_ff;
   logic [ALPHA_W-1:0]  galpha_ff;
   logic                mode_ff;
   logic                pos_dirty_ff;

   logic [FACTOR_W:0]   max_f;
   logic [WCMP_W-1:0]   max_w;
   logic [FACTOR_W-1:0] f_eff;
   logic [WIDTH_W-1:0]  w_eff;
   logic [ALPHA_W-1:0]  ga_eff;
   logic [SC_W-1:0]     row_len;
   logic [DEN_W-1:0]    dsq;

   assign max_f  = (FACTOR_W+1)'(MAX_FACTOR);
   assign max_w  = WCMP_W'(MAX_OUT_WIDTH);
   assign f_eff  = (factor_ff == '0) ? FACTOR_W'(1) :
                   ({1'b0, factor_ff} > max_f) ? max_f[FACTOR_W-1:0] : factor_ff;
   assign w_eff  = (out_width_ff == '0) ? WIDTH_W'(1) :
                   (WCMP_W'(out_width_ff) > max_w) ? max_w[WIDTH_W-1:0] : out_width_ff;
   assign ga_eff = (galpha_ff > ALPHA_ONE) ? ALPHA_ONE : galpha_ff;
   assign row_len = SC_W'(w_eff) * SC_W'(f_eff);
   assign dsq     = DEN_W'(f_eff) * DEN_W'(f_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff    <= FACTOR_W'(1);
         out_width_ff <= WIDTH_W'(1);
         galpha_ff    <= ALPHA_ONE;
         mode_ff      <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FACTOR:       factor_ff    <= csr_data[FACTOR_W-1:0];
            CSR_OUT_WIDTH:    out_width_ff <= csr_data[WIDTH_W-1:0];
            CSR_GLOBAL_ALPHA: galpha_ff    <= csr_data[ALPHA_W-1:0];
            CSR_TARGET_MODE:  mode_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   // position
   logic [SC_W-1:0]     sc_ff;
   logic [COL_W-1:0]    col_ff;
   logic [FACTOR_W-1:0] off_ff;
   logic [FACTOR_W-1:0] sub_ff;
   logic                first_sample;
   logic                last_sample;
   logic [SC_W-1:0]     sc_next;
   logic [FACTOR_W-1:0] f_last;

   assign f_last       = f_eff - 1'b1;
   assign first_sample = (sub_ff == '0) && (off_ff == '0);
   assign last_sample  = (sub_ff == f_last) && (off_ff == f_last);
   assign sc_next      = sc_ff + 1'b1;

   // divider lanes: red, green, blue, coverage; red lane also splits position
   logic [NUM_W-1:0] div_num [4];
   logic [NUM_W-1:0] div_quo [4];
   logic [DEN_W-1:0] div_rem [4];
   logic [3:0]       div_idle;
   logic [DEN_W-1:0] div_den;
   logic             div_start;

   logic [SUM_W-1:0] acc_r_ff, acc_g_ff, acc_b_ff;
   logic [CNT_W-1:0] acc_c_ff;
   logic [NUM_W-1:0] anum_ff;

   assign div_start  = cmd.pos_start | cmd.res_start;
   assign div_den    = cmd.pos_start ? DEN_W'(f_eff) : dsq;
   assign div_num[0] = cmd.pos_start ? NUM_W'(sc_ff) : NUM_W'(acc_r_ff);
   assign div_num[1] = NUM_W'(acc_g_ff);
   assign div_num[2] = NUM_W'(acc_b_ff);
   assign div_num[3] = anum_ff;

   for (genvar i = 0; i < 4; i++) begin : g_lane
      ssr_div u_div (
         .clock (clock),
         .reset (reset),
         .start (div_start),
         .num   (div_num[i]),
         .den   (div_den),
         .idle  (div_idle[i]),
         .quo   (div_quo[i]),
         .rem   (div_rem[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff        <= '0;
         col_ff       <= '0;
         off_ff       <= '0;
         sub_ff       <= '0;
         pos_dirty_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            pos_dirty_ff <= 1'b1;
         end
         if (cmd.accept) begin
            // drop a position left out of bounds by a reconfiguration
            if (sc_ff >= row_len) sc_ff <= '0;
            if (sub_ff >= f_eff) sub_ff <= '0;
         end
         if (cmd.pos_load) begin
            col_ff       <= div_quo[0][COL_W-1:0];
            off_ff       <= div_rem[0][FACTOR_W-1:0];
            pos_dirty_ff <= 1'b0;
         end
         if (cmd.rmw) begin
            if (sc_next >= row_len) begin
               sc_ff  <= '0;
               col_ff <= '0;
               off_ff <= '0;
               sub_ff <= (sub_ff + 1'b1 >= f_eff) ? '0 : sub_ff + 1'b1;
            end else begin
               sc_ff <= sc_next;
               if (off_ff == f_last) begin
                  off_ff <= '0;
                  col_ff <= col_ff + 1'b1;
               end else begin
                  off_ff <= off_ff + 1'b1;
               end
            end
         end
      end
   end

   // column accumulator memory
   logic [MEM_W-1:0] mem [MAX_OUT_WIDTH];
   logic [MEM_W-1:0] rd_ff;
   logic [CLR_W-1:0] clr_ff;
   logic             clear_done;

   assign clear_done = (clr_ff == CLR_W'(MAX_OUT_WIDTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step && !clear_done) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   req_data_type     in_ff;
   logic             covered;
   logic [SUM_W-1:0] new_r, new_g, new_b;
   logic [CNT_W-1:0] new_c;

   assign covered = !((in_ff.depth_bits >= FAR_LOW) && (in_ff.depth_bits <= FAR_HIGH));

   always_comb begin
      if (first_sample) begin
         new_r = SUM_W'(in_ff.sample_red);
         new_g = SUM_W'(in_ff.sample_green);
         new_b = SUM_W'(in_ff.sample_blue);
         new_c = CNT_W'(covered);
      end else begin
         new_r = rd_ff[MEM_W-1 -: SUM_W] + SUM_W'(in_ff.sample_red);
         new_g = rd_ff[CNT_W+2*SUM_W-1 -: SUM_W] + SUM_W'(in_ff.sample_green);
         new_b = rd_ff[CNT_W+SUM_W-1 -: SUM_W] + SUM_W'(in_ff.sample_blue);
         new_c = rd_ff[CNT_W-1:0] + CNT_W'(covered);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step && !clear_done) begin
         mem[clr_ff[COL_W-1:0]] <= '0;
      end else if (cmd.rmw) begin
         mem[col_ff] <= {new_r, new_g, new_b, new_c};
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[col_ff];
      end
   end

   // accumulate and resolve payload
   logic [COL_W-1:0]  res_col_ff;
   logic              res_end_ff;
   logic [DEN_W-1:0]  cnt_clip;
   logic [ALPHA_W-1:0] inv;
   logic [COLOR_W-1:0] tgt   [3];
   logic [COLOR_W-1:0] cavg  [3];
   logic [31:0]        cterm_ff [3];
   logic [32:0]        prod_ff  [3];
   logic [33:0]        mix   [3];
   logic [17:0]        mix_hi [3];
   logic [17:0]        limit;
   logic [COLOR_W-1:0] res   [3];
   rsp_data_type       rsp_ff;
   logic               rsp_valid_ff;

   assign cnt_clip = (DEN_W'(acc_c_ff) > dsq) ? dsq : DEN_W'(acc_c_ff);
   assign inv      = ALPHA_ONE - div_quo[3][ALPHA_W-1:0];
   assign tgt[0]   = mode_ff ? in_ff.target_red   : {8'h00, in_ff.target_red[7:0]};
   assign tgt[1]   = mode_ff ? in_ff.target_green : {8'h00, in_ff.target_green[7:0]};
   assign tgt[2]   = mode_ff ? in_ff.target_blue  : {8'h00, in_ff.target_blue[7:0]};
   assign limit    = mode_ff ? 18'd65535 : 18'd255;

   for (genvar i = 0; i < 3; i++) begin : g_chan
      assign cavg[i]   = (div_quo[i] > NUM_W'(COLOR_ONE)) ? COLOR_ONE :
                         div_quo[i][COLOR_W-1:0];
      assign mix[i]    = 34'(cterm_ff[i]) + 34'(prod_ff[i]);
      assign mix_hi[i] = mix[i][33:16];
      assign res[i]    = (mix_hi[i] > limit) ? limit[COLOR_W-1:0] : mix_hi[i][COLOR_W-1:0];

      always_ff @(posedge clock) begin
         if (cmd.mul) begin
            // fraction mode keeps the average whole by placing it above the
            // binary point, so both modes drop the same 16 bits
            cterm_ff[i] <= mode_ff ? {cavg[i], 16'h0000} : 32'(cavg[i]) * 32'd510;
            prod_ff[i]  <= 33'(inv) * 33'(tgt[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         in_ff <= req_data;
      end
      if (cmd.rmw) begin
         acc_r_ff   <= new_r;
         acc_g_ff   <= new_g;
         acc_b_ff   <= new_b;
         acc_c_ff   <= new_c;
         res_col_ff <= col_ff;
         res_end_ff <= (WCMP_W'(col_ff) == WCMP_W'(w_eff) - 1'b1);
      end
      if (cmd.res_prep) begin
         anum_ff <= NUM_W'(cnt_clip * ga_eff);
      end
      if (cmd.out_load) begin
         rsp_ff.out_red    <= res[0];
         rsp_ff.out_green  <= res[1];
         rsp_ff.out_blue   <= res[2];
         rsp_ff.out_column <= OUTCOL_W'(res_col_ff);
         rsp_ff.row_end    <= res_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_ff;
   assign status.clear_done  = clear_done;
   assign status.pos_dirty   = pos_dirty_ff;
   assign status.div_idle    = &div_idle;
   assign status.last_sample = last_sample;
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

endmodule

[design/ssr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_checker
// Port-level checks of the resolve block, bound to the top level.
// ----------------------------------------------------------------------------
module ssr_checker import ssr_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [COLOR_W-1:0]  out_red,
   input logic [OUTCOL_W-1:0] out_column,
   input logic                csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_red) && $stable(out_column))
      else $error("stalled result changed");

   a_clear_busy: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("sample taken during memory clear");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("back-to-back sample transfer");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr port stalled");

endmodule

bind supersample_resolve_alpha_composite ssr_checker u_ssr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_in.valid),
   .req_ready  (req_in.ready),
   .rsp_valid  (rsp_out.valid),
   .rsp_ready  (rsp_out.ready),
   .out_red    (rsp_out.out_red),
   .out_column (rsp_out.out_column),
   .csr_ready  (csr_in.ready)
);
